// ===== hdl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_POP_BACK   = 3'd1,
      REQ_PUSH_FRONT = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_COUNT      = 3'd4,
      REQ_CLEAR      = 3'd5
   } req_code_type;

   // Command broadcast to every cell of the chain at once.
   typedef enum logic [2:0] {
      CMD_HOLD       = 3'd0,
      CMD_LOAD_BACK  = 3'd1,
      CMD_DROP_BACK  = 3'd2,
      CMD_SHIFT_UP   = 3'd3,
      CMD_SHIFT_DOWN = 3'd4,
      CMD_CLEAR      = 3'd5
   } cell_cmd_type;

   typedef struct packed {
      logic                  occ;
      logic [DATA_WIDTH-1:0] data;
   } cell_link_type;

endpackage

`default_nettype wire

// ===== hdl/deq_cell.sv =====
`default_nettype none

module deq_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire deq_pkg::cell_cmd_type             cmd,
   input  wire deq_pkg::cell_link_type            prev_link,
   input  wire deq_pkg::cell_link_type            next_link,
   input  wire logic [deq_pkg::DATA_WIDTH-1:0]    word,
   output deq_pkg::cell_link_type                 link,
   output logic [deq_pkg::DATA_WIDTH-1:0]         tap
);

   logic                           occ_ff;
   logic                           occ_in;
   logic [deq_pkg::DATA_WIDTH-1:0] data_ff;
   logic [deq_pkg::DATA_WIDTH-1:0] data_in;

   logic is_back;
   logic is_slot;

   // The occupied cells always form one run starting at the front cell.
   assign is_back = occ_ff && !next_link.occ;
   assign is_slot = prev_link.occ && !occ_ff;

   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      unique case (cmd)
         deq_pkg::CMD_HOLD: begin
         end
         deq_pkg::CMD_LOAD_BACK: begin
            if (is_slot) begin
               occ_in  = 1'b1;
               data_in = word;
            end
         end
         deq_pkg::CMD_DROP_BACK: begin
            if (is_back) begin
               occ_in = 1'b0;
            end
         end
         deq_pkg::CMD_SHIFT_UP: begin
            occ_in  = prev_link.occ;
            data_in = prev_link.data;
         end
         deq_pkg::CMD_SHIFT_DOWN: begin
            occ_in  = next_link.occ;
            data_in = next_link.data;
         end
         deq_pkg::CMD_CLEAR: begin
            occ_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign link.occ  = occ_ff;
   assign link.data = data_ff;
   assign tap       = is_back ? data_ff : '0;

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_top.sv =====
// Channel   Handshake          Payload
// request   start / busy       req_type, req_data_in
// response  rsp_strobe         rsp_success, rsp_data_out, rsp_entry_count
//
// One item is taken in every cycle; busy stays low. Its result appears on the
// rsp_ ports in the next cycle, for one cycle, from the output registers.
// The words sit in a row of cells: a push or pop at the front shifts the whole
// row by one cell, a push or pop at the back touches only the cell at the end.
// Reset clears the count and every cell's occupied bit; the receiver cannot stall.
`default_nettype none

module double_ended_queue_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [2:0]                         req_type,
   input  wire logic [deq_pkg::DATA_WIDTH-1:0]     req_data_in,
   output logic                                    rsp_strobe,
   output logic                                    rsp_success,
   output logic [deq_pkg::DATA_WIDTH-1:0]          rsp_data_out,
   output logic [deq_pkg::CNT_W-1:0]               rsp_entry_count
);

   localparam int DEPTH = deq_pkg::DEPTH;
   localparam int DW    = deq_pkg::DATA_WIDTH;
   localparam int CW    = deq_pkg::CNT_W;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          strobe_ff;
   logic          success_ff;
   logic          success_in;
   logic [DW-1:0] data_out_ff;
   logic [DW-1:0] data_out_in;

   deq_pkg::cell_cmd_type  cmd;
   deq_pkg::cell_link_type cell_link [DEPTH];
   deq_pkg::cell_link_type prev_link [DEPTH];
   deq_pkg::cell_link_type next_link [DEPTH];
   logic [DW-1:0]          cell_tap  [DEPTH];
   logic [DW-1:0]          back_word;
   logic [DEPTH-1:0]       occ_vec;

   logic full;
   logic empty;

   assign busy  = 1'b0;
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            prev_link[i].occ  = 1'b1;
            prev_link[i].data = req_data_in;
         end else begin
            prev_link[i] = cell_link[i-1];
         end
         if (i == DEPTH - 1) begin
            next_link[i].occ  = 1'b0;
            next_link[i].data = '0;
         end else begin
            next_link[i] = cell_link[i+1];
         end
      end
   end

   // Only the back cell drives a nonzero tap.
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | cell_tap[i];
         occ_vec[i] = cell_link[i].occ;
      end
   end

   always_comb begin
      cmd         = deq_pkg::CMD_HOLD;
      count_in    = count_ff;
      success_in  = 1'b0;
      data_out_in = '0;
      if (start) begin
         unique case (req_type)
            deq_pkg::REQ_PUSH_BACK: begin
               if (!full) begin
                  cmd        = deq_pkg::CMD_LOAD_BACK;
                  count_in   = count_ff + CW'(1);
                  success_in = 1'b1;
               end
            end
            deq_pkg::REQ_POP_BACK: begin
               if (!empty) begin
                  cmd         = deq_pkg::CMD_DROP_BACK;
                  count_in    = count_ff - CW'(1);
                  success_in  = 1'b1;
                  data_out_in = back_word;
               end
            end
            deq_pkg::REQ_PUSH_FRONT: begin
               if (!full) begin
                  cmd        = deq_pkg::CMD_SHIFT_UP;
                  count_in   = count_ff + CW'(1);
                  success_in = 1'b1;
               end
            end
            deq_pkg::REQ_POP_FRONT: begin
               if (!empty) begin
                  cmd         = deq_pkg::CMD_SHIFT_DOWN;
                  count_in    = count_ff - CW'(1);
                  success_in  = 1'b1;
                  data_out_in = cell_link[0].data;
               end
            end
            deq_pkg::REQ_COUNT: begin
               success_in = 1'b1;
            end
            deq_pkg::REQ_CLEAR: begin
               cmd        = deq_pkg::CMD_CLEAR;
               count_in   = '0;
               success_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      deq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_link (prev_link[g]),
         .next_link (next_link[g]),
         .word      (req_data_in),
         .link      (cell_link[g]),
         .tap       (cell_tap[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      success_ff  <= success_in;
      data_out_ff <= data_out_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_success     = success_ff;
   assign rsp_data_out    = data_out_ff;
   assign rsp_entry_count = count_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_strobe)
      else $error("accepted item produced no result");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == int'(count_ff))
      else $error("entry count disagrees with occupied cells");

   a_cells_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((occ_vec + DEPTH'(1)) & occ_vec) == '0)
      else $error("occupied cells do not form one run from the front");

   a_full_push_refused: assert property (@(posedge clock) disable iff (reset)
      start && full && (req_type == deq_pkg::REQ_PUSH_BACK
                        || req_type == deq_pkg::REQ_PUSH_FRONT)
      |=> !rsp_success && $stable(count_ff))
      else $error("push on a full queue was not refused");

endmodule

`default_nettype wire
